// File: rtl/prrs_pkg.sv
package prrs_pkg;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_SLEEP   = 3'd1,
        CMD_UNREADY = 3'd2,
        CMD_WAKE    = 3'd3,
        CMD_SETPRIO = 3'd4
    } cmd_e;

    localparam logic [6:0] SLICE_RELOAD_RST = 7'd25;
    localparam logic signed [7:0] INITIAL_SLICE = 8'sd20;
    localparam logic [2:0] NOT_READY = 3'd1;

    typedef struct packed {
        logic [2:0] cmd;
        logic [5:0] task_id;
        logic [3:0] new_level;
        logic [2:0] sleep_state;
    } req_t;

    typedef struct packed {
        logic [5:0] run_task;
        logic       switched;
        logic       no_ready;
        logic       rejected;
    } rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DECODE,
        ST_RM_HEAD,
        ST_RM_WALK,
        ST_RM_WAIT,
        ST_RM_FIX,
        ST_POST_RM,
        ST_WAKE,
        ST_SCAN,
        ST_SC_HEAD,
        ST_SC_ROT,
        ST_SC_WALK,
        ST_SC_WAIT,
        ST_SC_LINK,
        ST_SC_CLR,
        ST_SC_DONE,
        ST_RESP
    } state_e;

endpackage

// File: rtl/priority_round_robin_task_scheduler_unit.sv
// A list removal and a tail rotation each walk a level list link by link.
// Throughput: one request at a time; the next is taken after the result is accepted.
// Reset: a clearing pass initializes every entry of the task memory; no request
//   is accepted during it.
module priority_round_robin_task_scheduler_unit
    import prrs_pkg::*;
#(
    parameter int NUM_TASKS  = 64,
    parameter int NUM_LEVELS = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  req_t       s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output rsp_t       m_data
);
    localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int CW = $clog2(NUM_TASKS + 1);

    typedef struct packed {
        logic [TW-1:0] nxt;
        logic          nok;
        logic [LW-1:0] lvl;
        logic [2:0]    status;
        logic signed [7:0] slice;
    } entry_t;

    // task memory
    entry_t mem [NUM_TASKS];
    logic [TW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    entry_t        wr_data, rd_q;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    // level heads live in flops
    logic [TW-1:0] head_reg [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] hok_reg;

    state_e state_reg, state_next;
    logic [6:0]    reload_reg;
    logic          clr_reg;
    logic [TW-1:0] clr_cnt_reg;
    req_t          req_reg;
    rsp_t          rsp_reg;
    logic          mvalid_reg;
    logic [TW-1:0] run_reg;
    entry_t        cur_reg;
    logic [TW-1:0] p_reg;
    entry_t        pe_reg;
    logic [CW-1:0] n_reg;
    logic [LW-1:0] lv_reg;
    logic [TW-1:0] h_reg;
    entry_t        he_reg;

    assign s_ready = (state_reg == ST_IDLE) && !clr_reg && !mvalid_reg;
    assign m_valid = mvalid_reg;
    assign m_data  = rsp_reg;

    wire do_rm = (req_reg.cmd == CMD_SLEEP) || (req_reg.cmd == CMD_UNREADY) ||
                 (req_reg.cmd == CMD_SETPRIO);
    wire [TW-1:0] wid = req_reg.task_id[TW-1:0];
    wire wid_ok = (32'(req_reg.task_id) < NUM_TASKS);
    wire [LW-1:0] cur_lv = cur_reg.lvl;
    wire [LW-1:0] new_lv = LW'(req_reg.new_level);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid && s_ready) state_next = ST_FETCH;
            ST_FETCH:  state_next = ST_DECODE;
            ST_DECODE: begin
                if (req_reg.cmd == CMD_TICK) state_next = ST_POST_RM;
                else if (req_reg.cmd == CMD_WAKE) state_next = wid_ok ? ST_WAKE : ST_SCAN;
                else if (req_reg.cmd == CMD_SETPRIO && 32'(req_reg.new_level) >= NUM_LEVELS)
                    state_next = ST_RESP;
                else if (do_rm) state_next = ST_RM_HEAD;
                else state_next = ST_RESP;
            end
            ST_RM_HEAD: begin
                if (!hok_reg[cur_lv] || head_reg[cur_lv] == run_reg) state_next = ST_POST_RM;
                else state_next = ST_RM_WAIT;
            end
            ST_RM_WAIT: state_next = ST_RM_WALK;
            ST_RM_WALK: begin
                if (!rd_q.nok || n_reg == CW'(NUM_TASKS)) state_next = ST_POST_RM;
                else if (rd_q.nxt == run_reg) state_next = ST_RM_FIX;
                else state_next = ST_RM_WAIT;
            end
            ST_RM_FIX:  state_next = ST_POST_RM;
            ST_POST_RM: begin
                if (req_reg.cmd == CMD_TICK)
                    state_next = (cur_reg.slice < 0) ? ST_SCAN : ST_RESP;
                else if (req_reg.cmd == CMD_SLEEP) state_next = ST_SCAN;
                else state_next = ST_RESP;
            end
            ST_WAKE:    state_next = ST_SCAN;
            ST_SCAN: begin
                if (hok_reg[lv_reg]) state_next = ST_SC_HEAD;
                else if (32'(lv_reg) == NUM_LEVELS - 1) state_next = ST_RESP;
            end
            ST_SC_HEAD: state_next = ST_SC_ROT;
            ST_SC_ROT: begin
                if (rd_q.slice <= 0 && rd_q.nok) state_next = ST_SC_WAIT;
                else state_next = ST_SC_DONE;
            end
            ST_SC_WAIT: state_next = ST_SC_WALK;
            ST_SC_WALK: begin
                if (!rd_q.nok || n_reg == CW'(NUM_TASKS)) state_next = ST_SC_LINK;
                else state_next = ST_SC_WAIT;
            end
            ST_SC_LINK: state_next = ST_SC_CLR;
            ST_SC_CLR:  state_next = ST_SC_DONE;
            ST_SC_DONE: state_next = ST_RESP;
            ST_RESP:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        rd_addr = run_reg;
        wr_en   = 1'b0;
        wr_addr = run_reg;
        wr_data = cur_reg;
        if (clr_reg) begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '{nxt: '0, nok: 1'b0, lvl: LW'(NUM_LEVELS - 1),
                        status: (clr_cnt_reg == '0) ? 3'd0 : NOT_READY,
                        slice: (clr_cnt_reg == '0) ? INITIAL_SLICE : 8'sd0};
        end else begin
            case (state_reg)
                ST_IDLE:   rd_addr = run_reg;
                ST_DECODE: rd_addr = wid;
                ST_RM_HEAD: rd_addr = head_reg[cur_lv];
                ST_RM_WAIT: rd_addr = p_reg;
                ST_RM_FIX: begin
                    wr_en = 1'b1; wr_addr = p_reg;
                    wr_data = pe_reg;
                    wr_data.nxt = cur_reg.nxt;
                    wr_data.nok = cur_reg.nok;
                end
                // write back the running task; sleep drops its link, set priority
                // pushes it at the head of the new level
                ST_POST_RM: begin
                    wr_en = 1'b1; wr_addr = run_reg;
                    if (req_reg.cmd == CMD_SLEEP) begin
                        wr_data.nok = 1'b0;
                        wr_data.nxt = '0;
                    end else if (req_reg.cmd == CMD_SETPRIO) begin
                        wr_data.lvl = new_lv;
                        wr_data.nxt = head_reg[new_lv];
                        wr_data.nok = hok_reg[new_lv];
                    end
                end
                ST_WAKE: if (rd_q.status != 3'd0) begin
                    wr_en = 1'b1; wr_addr = wid;
                    wr_data = rd_q;
                    wr_data.status = 3'd0;
                    wr_data.nxt = head_reg[rd_q.lvl];
                    wr_data.nok = hok_reg[rd_q.lvl];
                end
                ST_SCAN:    rd_addr = head_reg[lv_reg];
                ST_SC_HEAD: rd_addr = h_reg;
                // reload a lone expired head in place
                ST_SC_ROT: if (rd_q.slice <= 0 && !rd_q.nok) begin
                    wr_en = 1'b1; wr_addr = h_reg;
                    wr_data = rd_q;
                    wr_data.slice = 8'(reload_reg);
                end
                ST_SC_WAIT: rd_addr = p_reg;
                ST_SC_LINK: begin
                    wr_en = 1'b1; wr_addr = p_reg;
                    wr_data = pe_reg;
                    wr_data.nxt = h_reg;
                    wr_data.nok = 1'b1;
                end
                // reload the rotated head and cut its link after the tail is linked
                ST_SC_CLR: begin
                    wr_en = 1'b1; wr_addr = h_reg;
                    wr_data = he_reg;
                    wr_data.slice = 8'(reload_reg);
                    wr_data.nok = 1'b0;
                    wr_data.nxt = '0;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            reload_reg  <= SLICE_RELOAD_RST;
            mvalid_reg  <= 1'b0;
            run_reg     <= '0;
            hok_reg     <= {1'b1, {(NUM_LEVELS-1){1'b0}}};
            for (int i = 0; i < NUM_LEVELS; i++) head_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) reload_reg <= cfg_wdata;
            if (clr_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (32'(clr_cnt_reg) == NUM_TASKS - 1) clr_reg <= 1'b0;
            end
            if (mvalid_reg && m_ready) mvalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: if (s_valid && s_ready) begin
                    req_reg <= s_data;
                    rsp_reg <= '0;
                end
                ST_FETCH: cur_reg <= rd_q;
                ST_DECODE: begin
                    n_reg  <= '0;
                    lv_reg <= '0;
                    if (req_reg.cmd == CMD_TICK) begin
                        if (cur_reg.slice != -8'sd128) cur_reg.slice <= cur_reg.slice - 8'sd1;
                    end else if (req_reg.cmd == CMD_SETPRIO &&
                                 32'(req_reg.new_level) >= NUM_LEVELS) begin
                        rsp_reg.rejected <= 1'b1;
                    end else if (do_rm) begin
                        cur_reg.status <= (req_reg.cmd == CMD_SETPRIO) ? cur_reg.status
                                                                        : req_reg.sleep_state;
                    end
                end
                ST_RM_HEAD: begin
                    p_reg <= head_reg[cur_lv];
                    if (hok_reg[cur_lv] && head_reg[cur_lv] == run_reg) begin
                        head_reg[cur_lv] <= cur_reg.nxt;
                        hok_reg[cur_lv]  <= cur_reg.nok;
                    end
                end
                ST_RM_WALK: begin
                    pe_reg <= rd_q;
                    n_reg  <= n_reg + 1'b1;
                    if (rd_q.nxt != run_reg) p_reg <= rd_q.nxt;
                end
                // set priority: the running task becomes the new level's head
                ST_POST_RM: if (req_reg.cmd == CMD_SETPRIO) begin
                    head_reg[new_lv] <= run_reg;
                    hok_reg[new_lv]  <= 1'b1;
                end
                ST_WAKE: if (rd_q.status != 3'd0) begin
                    head_reg[rd_q.lvl] <= wid;
                    hok_reg[rd_q.lvl]  <= 1'b1;
                end
                ST_SCAN: begin
                    h_reg <= head_reg[lv_reg];
                    n_reg <= '0;
                    if (!hok_reg[lv_reg]) begin
                        if (32'(lv_reg) == NUM_LEVELS - 1) rsp_reg.no_ready <= 1'b1;
                        else lv_reg <= lv_reg + 1'b1;
                    end
                end
                ST_SC_ROT: if (rd_q.slice <= 0 && rd_q.nok) begin
                    head_reg[lv_reg] <= rd_q.nxt;
                    p_reg  <= rd_q.nxt;
                    he_reg <= rd_q;
                end
                ST_SC_WALK: begin
                    pe_reg <= rd_q;
                    n_reg  <= n_reg + 1'b1;
                    if (rd_q.nok && n_reg != CW'(NUM_TASKS)) p_reg <= rd_q.nxt;
                end
                ST_SC_DONE: if (head_reg[lv_reg] != run_reg) begin
                    run_reg <= head_reg[lv_reg];
                    rsp_reg.switched <= 1'b1;
                end
                ST_RESP: begin
                    mvalid_reg <= 1'b1;
                    rsp_reg.run_task <= 6'(run_reg);
                end
                default: ;
            endcase
        end
    end

    property p_no_accept_clr;
        @(posedge aclk) disable iff (!aresetn) clr_reg |-> !s_ready;
    endproperty
    a_no_accept_clr: assert property (p_no_accept_clr) else $error("accept during clear");

    property p_resp_valid;
        @(posedge aclk) disable iff (!aresetn) (state_reg == ST_RESP) |=> m_valid;
    endproperty
    a_resp_valid: assert property (p_resp_valid) else $error("result lost");

    property p_flags;
        @(posedge aclk) disable iff (!aresetn)
            m_valid |-> !(m_data.rejected && (m_data.switched || m_data.no_ready));
    endproperty
    a_flags: assert property (p_flags) else $error("conflicting flags");

endmodule
